### rtl/core/variable_width_bit_packer_unit_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the variable width bit packer
// Short concurrent assertion forms, clocked on clk, held off during reset.
// ---------------------------------------------------------------------------
`ifndef VARIABLE_WIDTH_BIT_PACKER_UNIT_DEFINES_SVH
`define VARIABLE_WIDTH_BIT_PACKER_UNIT_DEFINES_SVH

// Check an invariant at every clock edge out of reset.
`define VWBP_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error(msg);

// Check that a condition implies another in the same cycle.
`define VWBP_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

### rtl/core/vwbp_pkg.sv
// ---------------------------------------------------------------------------
// vwbp_pkg
// Shared constants and codes for the variable width bit packer.
// ---------------------------------------------------------------------------
`default_nettype none

package vwbp_pkg;

  localparam int unsigned BYTE_BITS   = 8;
  localparam int unsigned FIELD_BITS  = 32;   // width of the value field
  localparam int unsigned MAX_RESULTS = 4;    // bytes delivered per request at most
  localparam int unsigned NB_W        = 3;    // byte counter, holds 0..MAX_RESULTS

  localparam int unsigned IN_DATA_W   = 40;   // value + nbits, byte padded
  localparam int unsigned CNT_IN_W    = 6;

  // request opcodes (in_tuser)
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  // sequencer states
  localparam logic [0:0] ST_IDLE = 1'b0;
  localparam logic [0:0] ST_RUN  = 1'b1;

  typedef logic [BYTE_BITS-1:0] byte_t;

endpackage

`default_nettype wire

### rtl/core/variable_width_bit_packer_unit.sv
// ---------------------------------------------------------------------------
// variable_width_bit_packer_unit
// Packs 1 to VALUE_WIDTH bit values into a byte stream, MSB first, keeping
// up to seven pending bits between requests; a flush emits the partial byte.
// ---------------------------------------------------------------------------
//  channel | dir | ports                        | contents
//  in_     | in  | tvalid tready tdata tuser    | value, nbits / op
//  out_    | out | tvalid tready tdata tlast     | out_byte / last
//
//  A write is accepted, then runs one step per chunk: a chunk is at
//  most 8 - pending bits, so a write of n bits with p pending runs
//  ceil((p + n) / 8) steps; a flush runs one step. The single chunk
//  shifter in the step loop sets these step counts.
//  Writes of zero bits and flushes with nothing pending finish on accept.
//  A step waits while the output register holds a byte not yet taken.
//  Reset (rst_n low, synchronous) clears the pending bits and the sequencer.
// ---------------------------------------------------------------------------
`default_nettype none

`include "variable_width_bit_packer_unit_defines.svh"

module variable_width_bit_packer_unit #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // [31:0] value, [37:32] nbits, [39:38] zero
  input  wire logic [vwbp_pkg::IN_DATA_W-1:0]   in_tdata,
  // [0] op
  input  wire logic                             in_tuser,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // [7:0] out_byte
  output logic [vwbp_pkg::BYTE_BITS-1:0]        out_tdata,
  output logic                                  out_tlast,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready
);

  import vwbp_pkg::*;

  // counter wide enough for VALUE_WIDTH itself
  localparam int unsigned CW = $clog2(VALUE_WIDTH + 1);
  // compare width for saturating the 6-bit count field
  localparam int unsigned EW = (CW > CNT_IN_W) ? CW : CNT_IN_W;

  // request fields
  logic [FIELD_BITS-1:0] in_value;
  logic [CNT_IN_W-1:0]   in_nbits;
  logic [CW-1:0]         cnt_sat;

  assign in_value = in_tdata[FIELD_BITS-1:0];
  assign in_nbits = in_tdata[FIELD_BITS +: CNT_IN_W];

  // clamp nbits to VALUE_WIDTH
  assign cnt_sat = (EW'(in_nbits) > EW'(VALUE_WIDTH)) ? CW'(VALUE_WIDTH)
                                                       : CW'(in_nbits);

  // sequencer and working registers
  logic [0:0]             state_r;
  logic                   op_r;
  logic [VALUE_WIDTH-1:0] v_r;
  logic [CW-1:0]          cnt_r;
  logic [NB_W-1:0]        nb_r;
  logic [6:0]             pend_bits_r;
  logic [2:0]             pend_cnt_r;

  // output register
  logic                   out_valid_r;
  byte_t                  out_data_r;
  logic                   out_last_r;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  // a step may run when the output register is empty or being drained
  logic slot_free;
  assign slot_free = !out_valid_r || out_tready;

  // shared chunk unit: take the top bits of what remains, place them above
  // the pending bits
  logic [3:0]             take_lim;
  logic [3:0]             take;
  logic [CW-1:0]          sh;
  logic [VALUE_WIDTH-1:0] shifted;
  byte_t                  chunk_mask;
  byte_t                  chunk;
  byte_t                  acc;
  logic [3:0]             sum_cnt;
  logic                   emit;
  logic [CW-1:0]          cnt_rem;
  logic                   byte_last;
  logic                   byte_keep;
  logic                   load_byte;

  assign take_lim   = 4'(BYTE_BITS) - {1'b0, pend_cnt_r};
  assign take       = (cnt_r < CW'(take_lim)) ? 4'(cnt_r) : take_lim;
  assign sh         = cnt_r - CW'(take);
  assign shifted    = v_r >> sh;
  assign chunk_mask = BYTE_BITS'((9'd1 << take) - 9'd1);
  assign chunk      = shifted[BYTE_BITS-1:0] & chunk_mask;
  assign acc        = {1'b0, pend_bits_r} | (chunk << pend_cnt_r);
  assign sum_cnt    = {1'b0, pend_cnt_r} + take;
  assign emit       = sum_cnt[3];
  assign cnt_rem    = sh;
  // the final byte: nothing whole remains, or the result budget is used up
  assign byte_last  = (cnt_rem < CW'(BYTE_BITS)) || (nb_r == NB_W'(MAX_RESULTS - 1));
  // bytes beyond the budget are dropped, the pending state still advances
  assign byte_keep  = (nb_r < NB_W'(MAX_RESULTS));
  // a byte enters the output register on this step
  assign load_byte  = (state_r == ST_RUN) && slot_free &&
                      ((op_r == OP_FLUSH) || (emit && byte_keep));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      nb_r        <= '0;
      pend_bits_r <= '0;
      pend_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // load a new byte, or drop the one taken
      if (load_byte) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_tvalid) begin
            op_r  <= in_tuser;
            v_r   <= VALUE_WIDTH'(in_value);
            cnt_r <= cnt_sat;
            nb_r  <= '0;
            if (in_tuser == OP_FLUSH) begin
              if (pend_cnt_r != 3'd0) begin
                state_r <= ST_RUN;
              end
            end else if (cnt_sat != '0) begin
              state_r <= ST_RUN;
            end
          end
        end
        ST_RUN: begin
          if (slot_free) begin
            if (op_r == OP_FLUSH) begin
              out_data_r  <= {1'b0, pend_bits_r};
              out_last_r  <= 1'b1;
              pend_bits_r <= '0;
              pend_cnt_r  <= '0;
              state_r     <= ST_IDLE;
            end else begin
              if (emit) begin
                pend_bits_r <= '0;
                pend_cnt_r  <= '0;
                if (byte_keep) begin
                  out_data_r  <= acc;
                  out_last_r  <= byte_last;
                  nb_r        <= nb_r + NB_W'(1);
                end
              end else begin
                pend_bits_r <= acc[6:0];
                pend_cnt_r  <= sum_cnt[2:0];
              end
              cnt_r <= cnt_rem;
              if (cnt_rem == '0) begin
                state_r <= ST_IDLE;
              end
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  logic run_write;
  logic run_flush;
  assign run_write = (state_r == ST_RUN) && (op_r == OP_WRITE);
  assign run_flush = (state_r == ST_RUN) && (op_r == OP_FLUSH);

  // pending bits above the pending count are always clear
  `VWBP_ASSERT_ALWAYS(a_pend_clean, (7'(pend_bits_r >> pend_cnt_r) == 7'd0), "pending bits dirty")
  // a running write always has bits left
  `VWBP_ASSERT_IMPLY(a_run_write, run_write, (cnt_r != '0), "write running with no bits")
  // a running flush always has a partial byte
  `VWBP_ASSERT_IMPLY(a_run_flush, run_flush, (pend_cnt_r != 3'd0), "flush with nothing pending")
  // never more bytes than the budget
  `VWBP_ASSERT_ALWAYS(a_nb_bound, (nb_r <= NB_W'(MAX_RESULTS)), "byte budget exceeded")

endmodule

`default_nettype wire

### bench/variable_width_bit_packer_unit_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// variable_width_bit_packer_unit_test
// Drives write and flush requests into the bit packer and checks every
// emitted byte and its tlast flag against a cycle-free model of the packer.
// ---------------------------------------------------------------------------

module variable_width_bit_packer_unit_test;

  import vwbp_pkg::*;

  localparam int unsigned RAND_REQUESTS = 470;
  localparam int unsigned IDLE_PCT      = 24;     // idle chance per cycle, both sides
  localparam int unsigned HOLD_LEN      = 250;    // long receiver hold-off, in cycles
  localparam int unsigned HOLD_AT       = 100;    // random request that starts the hold-off
  localparam int unsigned QUIET_FROM    = 250;    // window with no idling on either side
  localparam int unsigned QUIET_TO      = 330;
  localparam int unsigned DRAIN_WAIT    = 5000;
  localparam int unsigned TAIL_CYCLES   = 20;
  localparam int unsigned CYCLE_LIMIT   = 200000;

  // One emitted byte as the packer should deliver it.
  typedef struct packed {
    byte_t data;
    logic  last;
  } byte_due_t;

  // One row of the directed table. Rows with typed set carry their bytes
  // (first byte in b[0]); the others take their bytes from the model.
  typedef struct packed {
    logic             op;
    logic [31:0]      value;
    logic [5:0]       count;
    logic             typed;
    logic [2:0]       n;
    logic [0:3][7:0]  b;
  } stim_row_t;

  localparam int unsigned DIR_ROWS = 25;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic        in_tuser   = OP_WRITE;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  byte_t       out_tdata;
  logic        out_tlast;
  logic        out_tvalid;
  logic        out_tready = 1'b0;

  // Packer model state: pending bits at the low positions and their count.
  logic [6:0]  pend_bits;
  int unsigned pend_cnt;
  // Bytes the last modeled request emits.
  byte_t       req_bytes [MAX_RESULTS];
  int unsigned req_n;

  byte_due_t   byte_due_q [$];
  byte_due_t   due_head;
  stim_row_t   dir_rows [DIR_ROWS];

  int unsigned err_count   = 0;
  logic        quiet       = 1'b0;   // set while neither side idles
  logic        hold_req    = 1'b0;   // asks the receiver for its long hold-off
  logic        hold_done   = 1'b0;
  int unsigned hold_cycles = 0;

  variable_width_bit_packer_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [63:0] low_ones(input int unsigned n);
    if (n >= 64) return '1;
    return (64'd1 << n) - 64'd1;
  endfunction

  function automatic stim_row_t row(input logic op, input logic [31:0] value,
                                    input logic [5:0] count, input logic typed,
                                    input logic [2:0] n, input logic [31:0] b);
    stim_row_t r;
    r.op    = op;
    r.value = value;
    r.count = count;
    r.typed = typed;
    r.n     = n;
    r.b     = b;
    return r;
  endfunction

  // Record one emitted byte; drop anything past the per-request bound.
  task automatic emit_byte(input byte_t data);
    if (req_n < MAX_RESULTS) begin
      req_bytes[req_n] = data;
      req_n++;
    end
  endtask

  // Model one request: update the pending bits and collect the bytes out.
  task automatic pack_request(input logic op, input logic [31:0] value,
                              input logic [5:0] count);
    logic [63:0] v;
    int unsigned cnt;
    int unsigned take;
    byte_t       chunk;
    byte_t       acc;
    req_n = 0;
    if (op == OP_FLUSH) begin
      // Flush: emit the partial byte, zero above the pending bits.
      if (pend_cnt > 0) begin
        emit_byte({1'b0, pend_bits});
        pend_bits = '0;
        pend_cnt  = 0;
      end
    end else begin
      // Saturate the count to the field width, drop bits above it.
      cnt = (count > FIELD_BITS) ? FIELD_BITS : count;
      v   = {32'd0, value} & low_ones(cnt);
      while (cnt > 0) begin
        if (pend_cnt == 0) begin
          // Nothing pending: whole top bytes go straight out.
          while (cnt >= BYTE_BITS) begin
            emit_byte(byte_t'(v >> (cnt - BYTE_BITS)));
            cnt -= BYTE_BITS;
            v &= low_ones(cnt);
          end
          pend_bits = v[6:0];
          pend_cnt  = cnt;
          cnt       = 0;
        end else begin
          // Bits pending: place the next top chunk just above them.
          take = BYTE_BITS - pend_cnt;
          if (cnt < take) take = cnt;
          chunk = byte_t'((v >> (cnt - take)) & low_ones(take));
          acc   = {1'b0, pend_bits} | byte_t'(chunk << pend_cnt);
          pend_cnt += take;
          if (pend_cnt == BYTE_BITS) begin
            emit_byte(acc);
            pend_bits = '0;
            pend_cnt  = 0;
          end else begin
            pend_bits = acc[6:0];
          end
          cnt -= take;
          v &= low_ones(cnt);
        end
      end
    end
  endtask

  // Offer one request, hold it until accepted, then queue its bytes.
  // Typed rows queue their own bytes; the model still advances its state.
  task automatic issue_request(input logic op, input logic [31:0] value,
                               input logic [5:0] count, input logic typed,
                               input logic [2:0] n, input logic [0:3][7:0] b);
    byte_due_t due;
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {2'b00, count, value};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pack_request(op, value, count);
    if (typed) begin
      for (int unsigned i = 0; i < n; i++) begin
        due.data = b[i];
        due.last = (i == n - 1);
        byte_due_q.push_back(due);
      end
    end else begin
      for (int unsigned i = 0; i < req_n; i++) begin
        due.data = req_bytes[i];
        due.last = (i == req_n - 1);
        byte_due_q.push_back(due);
      end
    end
  endtask

  // Receiver: random stalls, one long hold-off on request, none while quiet.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      out_tready  <= 1'b0;
      hold_cycles <= hold_cycles + 1;
      if (hold_cycles == HOLD_LEN - 1) hold_done <= 1'b1;
    end else if (quiet) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Compare every accepted byte with the oldest one queued.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (byte_due_q.size() == 0) begin
        $error("out_byte: no byte queued, got %h", out_tdata);
        err_count++;
      end else begin
        due_head = byte_due_q.pop_front();
        if (out_tdata !== due_head.data) begin
          $error("out_byte: expected %h, got %h", due_head.data, out_tdata);
          err_count++;
        end
        if (out_tlast !== due_head.last) begin
          $error("last: expected %b, got %b", due_head.last, out_tlast);
          err_count++;
        end
      end
    end
  end

  // Abort a hung run.
  initial begin
    for (int unsigned c = 0; c < CYCLE_LIMIT; c++) @(posedge clk);
    $display("Mismatches found");
    $finish;
  end

  initial begin
    logic        op;
    logic [5:0]  count;
    int unsigned pick;

    // Directed table: extremes, both ops, and each corner of the packer.
    dir_rows[0]  = row(OP_WRITE, 32'hFFFF_FFFF, 6'd32, 1'b1, 3'd4, 32'hFFFF_FFFF);
    dir_rows[1]  = row(OP_WRITE, 32'h0000_0000, 6'd32, 1'b1, 3'd4, 32'h0000_0000);
    // flush with nothing pending
    dir_rows[2]  = row(OP_FLUSH, 32'h0000_0000, 6'd0,  1'b1, 3'd0, 32'h0);
    // zero bit count
    dir_rows[3]  = row(OP_WRITE, 32'hFFFF_FFFF, 6'd0,  1'b1, 3'd0, 32'h0);
    dir_rows[4]  = row(OP_WRITE, 32'h0000_00A5, 6'd8,  1'b1, 3'd1, 32'hA500_0000);
    // bit count too large saturates to 32
    dir_rows[5]  = row(OP_WRITE, 32'h1234_5678, 6'd63, 1'b1, 3'd4, 32'h1234_5678);
    // bits above the count ignored, then flushed out
    dir_rows[6]  = row(OP_WRITE, 32'hFFFF_FFFF, 6'd3,  1'b1, 3'd0, 32'h0);
    dir_rows[7]  = row(OP_FLUSH, 32'h0000_0000, 6'd0,  1'b1, 3'd1, 32'h0700_0000);
    dir_rows[8]  = row(OP_WRITE, 32'hFFFF_FFF0, 6'd4,  1'b1, 3'd0, 32'h0);
    dir_rows[9]  = row(OP_WRITE, 32'hFFFF_FFFF, 6'd1,  1'b1, 3'd0, 32'h0);
    dir_rows[10] = row(OP_FLUSH, 32'h0000_0000, 6'd0,  1'b1, 3'd1, 32'h1000_0000);
    dir_rows[11] = row(OP_WRITE, 32'h0000_0001, 6'd1,  1'b1, 3'd0, 32'h0);
    dir_rows[12] = row(OP_WRITE, 32'hFFFF_FFFF, 6'd32, 1'b0, 3'd0, 32'h0);
    dir_rows[13] = row(OP_FLUSH, 32'h0000_0000, 6'd0,  1'b0, 3'd0, 32'h0);
    dir_rows[14] = row(OP_WRITE, 32'h0000_007F, 6'd7,  1'b1, 3'd0, 32'h0);
    dir_rows[15] = row(OP_WRITE, 32'h0000_0000, 6'd33, 1'b0, 3'd0, 32'h0);
    dir_rows[16] = row(OP_FLUSH, 32'h0000_0000, 6'd0,  1'b0, 3'd0, 32'h0);
    dir_rows[17] = row(OP_WRITE, 32'h8000_0000, 6'd32, 1'b1, 3'd4, 32'h8000_0000);
    dir_rows[18] = row(OP_WRITE, 32'h0000_0001, 6'd32, 1'b1, 3'd4, 32'h0000_0001);
    dir_rows[19] = row(OP_WRITE, 32'hDEAD_BEEF, 6'd17, 1'b0, 3'd0, 32'h0);
    dir_rows[20] = row(OP_WRITE, 32'h0000_0015, 6'd5,  1'b0, 3'd0, 32'h0);
    dir_rows[21] = row(OP_FLUSH, 32'h0000_0000, 6'd0,  1'b0, 3'd0, 32'h0);
    dir_rows[22] = row(OP_FLUSH, 32'h0000_0000, 6'd0,  1'b1, 3'd0, 32'h0);
    // flush ignores value and count
    dir_rows[23] = row(OP_FLUSH, 32'hFFFF_FFFF, 6'd63, 1'b1, 3'd0, 32'h0);
    dir_rows[24] = row(OP_WRITE, 32'h0000_005A, 6'd40, 1'b1, 3'd4, 32'h0000_005A);

    pend_bits = '0;
    pend_cnt  = 0;

    // Hold reset, then release it.
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    for (int unsigned i = 0; i < DIR_ROWS; i++)
      issue_request(dir_rows[i].op, dir_rows[i].value, dir_rows[i].count,
                    dir_rows[i].typed, dir_rows[i].n, dir_rows[i].b);

    // Random requests: mostly in-range writes, some flushes, and a few
    // zero or oversized counts.
    for (int unsigned i = 0; i < RAND_REQUESTS; i++) begin
      if (i == HOLD_AT) hold_req <= 1'b1;
      if (i == QUIET_FROM) quiet <= 1'b1;
      if (i == QUIET_TO) quiet <= 1'b0;
      op   = ($urandom_range(99) < 12) ? OP_FLUSH : OP_WRITE;
      pick = $urandom_range(99);
      if (pick < 4)       count = 6'd0;
      else if (pick < 9)  count = 6'($urandom_range(63, 33));
      else                count = 6'($urandom_range(32, 1));
      issue_request(op, $urandom, count, 1'b0, 3'd0, 32'h0);
    end
    in_tvalid <= 1'b0;

    // Drain: wait for every queued byte, then watch for strays.
    for (int unsigned w = 0; w < DRAIN_WAIT && byte_due_q.size() > 0; w++)
      @(posedge clk);
    if (byte_due_q.size() > 0) begin
      $error("out_byte: %0d bytes never arrived", byte_due_q.size());
      err_count++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);

    if (err_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### files.f
+incdir+rtl/core
rtl/core/vwbp_pkg.sv
rtl/core/variable_width_bit_packer_unit.sv
bench/variable_width_bit_packer_unit_test.sv
